[rtl/mrbss_pkg.sv]
// Shared types and constants of the best-short-side rectangle packer.
package mrbss_pkg;

   // Fixed width of the beat fields and configuration registers, and the reset atlas size.
   localparam int REQ_BITS = 13;
   localparam int ATLAS_RESET = 1024;

   // Configuration register indexes.
   localparam logic CSR_ATLAS_WIDTH = 1'b0;
   localparam logic CSR_ATLAS_HEIGHT = 1'b1;

   // Request action codes.
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   // Remainders cut from one overlapped free rectangle, in emission order.
   typedef enum logic [1:0] {
      PIECE_LEFT = 2'd0,
      PIECE_RIGHT = 2'd1,
      PIECE_TOP = 2'd2,
      PIECE_BOTTOM = 2'd3
   } piece_type;

   typedef struct packed {
      logic init;         // write the reset atlas as the only free rectangle
      logic clear;        // write the configured atlas as the only free rectangle
      logic req_load;     // capture the request beat
      logic find_clr;     // start a best-fit search
      logic find_eval;    // table read data is a search candidate
      logic rd_a_en;
      logic rd_b_en;
      logic split_clr;
      logic split_latch;  // table read data is the rectangle to split
      logic split_emit;
      piece_type piece;
      logic prune_clr;
      logic prune_load;   // split buffer read data is the rectangle under test
      logic prune_eval;   // split buffer read data is a possible container
      logic eval_same;
      logic eval_later;
      logic prune_keep;
      logic prune_done;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic found;
   } dp_status_type;

endpackage

[rtl/mrbss_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module mrbss_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mrbss_dp.sv]
// Datapath of the packer: free rectangle tables, best-fit search, split and prune logic.
module mrbss_dp import mrbss_pkg::*; #(
   parameter int MAX_FREE_RECTS = 64,
   parameter int COORD_BITS = 13,
   parameter int IDX_BITS = $clog2(MAX_FREE_RECTS),
   parameter int COUNT_BITS = $clog2(MAX_FREE_RECTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [IDX_BITS-1:0]   rd_addr,
   input  logic [REQ_BITS-1:0]   req_width,
   input  logic [REQ_BITS-1:0]   req_height,
   input  logic                  csr_wr_en,
   input  logic                  csr_addr,
   input  logic [REQ_BITS-1:0]   csr_wdata,
   output logic                  rsp_placed,
   output logic [REQ_BITS-1:0]   rsp_pos_x,
   output logic [REQ_BITS-1:0]   rsp_pos_y,
   output logic                  rsp_list_overflow,
   output logic [COUNT_BITS-1:0] free_count,
   output logic [COUNT_BITS-1:0] split_count,
   output dp_status_type         status
);

   localparam int C = COORD_BITS;
   localparam int RECT_BITS = 4 * C;
   localparam int CMP_BITS = (C > REQ_BITS) ? C : REQ_BITS;
   localparam logic [C-1:0] RESET_SIZE = C'(ATLAS_RESET % (1 << C));
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_FREE_RECTS);

   logic [C-1:0] atlas_w_ff, atlas_w_in, atlas_h_ff, atlas_h_in;
   logic [COUNT_BITS-1:0] free_count_ff, free_count_in;
   logic [COUNT_BITS-1:0] split_count_ff, split_count_in;
   logic [COUNT_BITS-1:0] keep_ff, keep_in;
   logic [REQ_BITS-1:0] req_w_ff, req_w_in, req_h_ff, req_h_in;
   logic found_ff, found_in, ovf_ff, ovf_in, dom_ff, dom_in;
   logic [CMP_BITS-1:0] best_s_ff, best_s_in;
   logic [C-1:0] bx0_ff, bx0_in, by0_ff, by0_in, bx1_ff, bx1_in, by1_ff, by1_in;
   logic [RECT_BITS-1:0] cur_ff, cur_in;
   logic rsp_placed_ff, rsp_placed_in, rsp_ovf_ff, rsp_ovf_in;
   logic [REQ_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic [RECT_BITS-1:0] a_rdata, b_rdata, a_wdata, b_wdata;
   logic a_we, b_we;
   logic [IDX_BITS-1:0] a_waddr;

   // Search candidate fields.
   logic [C-1:0] fx0, fy0, fx1, fy1, fw, fh;
   logic [CMP_BITS-1:0] fw_e, fh_e, rw_e, rh_e, lw, lh, short_side, px1_e, py1_e;
   logic fits, better;

   // Split fields.
   logic [C-1:0] sx0, sy0, sx1, sy1;
   logic overlap, piece_ok;
   logic [RECT_BITS-1:0] piece_rect;

   // Prune fields.
   logic [C-1:0] cx0, cy0, cx1, cy1, ox0, oy0, ox1, oy1;
   logic contained, equal;

   mrbss_ram #(.WIDTH(RECT_BITS), .DEPTH(MAX_FREE_RECTS), .ADDR_BITS(IDX_BITS)) u_table (
      .clock  (clock),
      .wr_en  (a_we),
      .wr_addr(a_waddr),
      .wr_data(a_wdata),
      .rd_en  (cmd.rd_a_en),
      .rd_addr(rd_addr),
      .rd_data(a_rdata)
   );

   mrbss_ram #(.WIDTH(RECT_BITS), .DEPTH(MAX_FREE_RECTS), .ADDR_BITS(IDX_BITS)) u_split (
      .clock  (clock),
      .wr_en  (b_we),
      .wr_addr(split_count_ff[IDX_BITS-1:0]),
      .wr_data(b_wdata),
      .rd_en  (cmd.rd_b_en),
      .rd_addr(rd_addr),
      .rd_data(b_rdata)
   );

   always_comb begin
      {fx0, fy0, fx1, fy1} = a_rdata;
      fw = fx1 - fx0;
      fh = fy1 - fy0;
      fw_e = CMP_BITS'(fw);
      fh_e = CMP_BITS'(fh);
      rw_e = CMP_BITS'(req_w_ff);
      rh_e = CMP_BITS'(req_h_ff);
      fits = (fw_e >= rw_e) && (fh_e >= rh_e);
      lw = fw_e - rw_e;
      lh = fh_e - rh_e;
      short_side = (lw < lh) ? lw : lh;
      better = fits && (!found_ff || short_side < best_s_ff);
      px1_e = CMP_BITS'(fx0) + rw_e;
      py1_e = CMP_BITS'(fy0) + rh_e;
   end

   always_comb begin
      {sx0, sy0, sx1, sy1} = cur_ff;
      overlap = !(bx1_ff <= sx0 || bx0_ff >= sx1 || by1_ff <= sy0 || by0_ff >= sy1);
      piece_ok = 1'b0;
      piece_rect = cur_ff;
      if (!overlap) begin
         piece_ok = (cmd.piece == PIECE_LEFT);
      end else begin
         case (cmd.piece)
            PIECE_LEFT: begin
               piece_ok = bx0_ff > sx0;
               piece_rect = {sx0, sy0, bx0_ff, sy1};
            end
            PIECE_RIGHT: begin
               piece_ok = bx1_ff < sx1;
               piece_rect = {bx1_ff, sy0, sx1, sy1};
            end
            PIECE_TOP: begin
               piece_ok = by0_ff > sy0;
               piece_rect = {sx0, sy0, sx1, by0_ff};
            end
            PIECE_BOTTOM: begin
               piece_ok = by1_ff < sy1;
               piece_rect = {sx0, by1_ff, sx1, sy1};
            end
            default: begin
               piece_ok = 1'b0;
            end
         endcase
      end
      b_wdata = piece_rect;
      b_we = cmd.split_emit && piece_ok && (split_count_ff < MAX_COUNT);
   end

   always_comb begin
      {cx0, cy0, cx1, cy1} = cur_ff;
      {ox0, oy0, ox1, oy1} = b_rdata;
      contained = (cx0 >= ox0) && (cy0 >= oy0) && (cx1 <= ox1) && (cy1 <= oy1);
      equal = (cur_ff == b_rdata);
   end

   always_comb begin
      a_we = cmd.init || cmd.clear || (cmd.prune_keep && !dom_ff);
      a_waddr = cmd.prune_keep ? keep_ff[IDX_BITS-1:0] : '0;
      if (cmd.init) begin
         a_wdata = {{C{1'b0}}, {C{1'b0}}, RESET_SIZE, RESET_SIZE};
      end else if (cmd.clear) begin
         a_wdata = {{C{1'b0}}, {C{1'b0}}, atlas_w_ff, atlas_h_ff};
      end else begin
         a_wdata = cur_ff;
      end
   end

   always_comb begin
      atlas_w_in = atlas_w_ff;
      atlas_h_in = atlas_h_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_ATLAS_WIDTH: atlas_w_in = C'(csr_wdata);
            CSR_ATLAS_HEIGHT: atlas_h_in = C'(csr_wdata);
            default: atlas_w_in = atlas_w_ff;
         endcase
      end

      free_count_in = free_count_ff;
      if (cmd.init || cmd.clear) begin
         free_count_in = COUNT_BITS'(1);
      end else if (cmd.prune_done) begin
         free_count_in = keep_ff;
      end

      req_w_in = cmd.req_load ? req_width : req_w_ff;
      req_h_in = cmd.req_load ? req_height : req_h_ff;

      found_in = found_ff;
      best_s_in = best_s_ff;
      bx0_in = bx0_ff;
      by0_in = by0_ff;
      bx1_in = bx1_ff;
      by1_in = by1_ff;
      if (cmd.find_clr || cmd.clear) begin
         found_in = 1'b0;
      end else if (cmd.find_eval && better) begin
         found_in = 1'b1;
         best_s_in = short_side;
         bx0_in = fx0;
         by0_in = fy0;
         bx1_in = C'(px1_e);
         by1_in = C'(py1_e);
      end

      split_count_in = split_count_ff;
      ovf_in = ovf_ff;
      if (cmd.split_clr) begin
         split_count_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.split_emit && piece_ok) begin
         if (split_count_ff < MAX_COUNT) begin
            split_count_in = split_count_ff + COUNT_BITS'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      cur_in = cur_ff;
      if (cmd.split_latch) begin
         cur_in = a_rdata;
      end else if (cmd.prune_load) begin
         cur_in = b_rdata;
      end

      // Of two equal rectangles only the later one survives.
      dom_in = dom_ff;
      if (cmd.prune_load) begin
         dom_in = 1'b0;
      end else if (cmd.prune_eval && contained && !cmd.eval_same &&
                   (!equal || cmd.eval_later)) begin
         dom_in = 1'b1;
      end

      keep_in = keep_ff;
      if (cmd.prune_clr) begin
         keep_in = '0;
      end else if (cmd.prune_keep && !dom_ff) begin
         keep_in = keep_ff + COUNT_BITS'(1);
      end

      rsp_placed_in = rsp_placed_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_ovf_in = rsp_ovf_ff;
      if (cmd.rsp_load) begin
         rsp_placed_in = found_ff;
         rsp_x_in = found_ff ? REQ_BITS'(bx0_ff) : '0;
         rsp_y_in = found_ff ? REQ_BITS'(by0_ff) : '0;
         rsp_ovf_in = found_ff && ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_w_ff <= RESET_SIZE;
         atlas_h_ff <= RESET_SIZE;
         free_count_ff <= COUNT_BITS'(1);
         found_ff <= 1'b0;
         split_count_ff <= '0;
         ovf_ff <= 1'b0;
         keep_ff <= '0;
         dom_ff <= 1'b0;
      end else begin
         atlas_w_ff <= atlas_w_in;
         atlas_h_ff <= atlas_h_in;
         free_count_ff <= free_count_in;
         found_ff <= found_in;
         split_count_ff <= split_count_in;
         ovf_ff <= ovf_in;
         keep_ff <= keep_in;
         dom_ff <= dom_in;
      end
   end

   always_ff @(posedge clock) begin
      req_w_ff <= req_w_in;
      req_h_ff <= req_h_in;
      best_s_ff <= best_s_in;
      bx0_ff <= bx0_in;
      by0_ff <= by0_in;
      bx1_ff <= bx1_in;
      by1_ff <= by1_in;
      cur_ff <= cur_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_placed = rsp_placed_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_list_overflow = rsp_ovf_ff;
   assign free_count = free_count_ff;
   assign split_count = split_count_ff;
   assign status.found = found_ff;

endmodule

[rtl/mrbss_ctrl.sv]
// Controller of the packer: sequences search, split and prune passes and the handshakes.
module mrbss_ctrl import mrbss_pkg::*; #(
   parameter int MAX_FREE_RECTS = 64,
   parameter int IDX_BITS = $clog2(MAX_FREE_RECTS),
   parameter int COUNT_BITS = $clog2(MAX_FREE_RECTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [COUNT_BITS-1:0] free_count,
   input  logic [COUNT_BITS-1:0] split_count,
   input  dp_status_type         status,
   output dp_cmd_type            cmd,
   output logic [IDX_BITS-1:0]   rd_addr
);

   typedef enum logic [11:0] {
      S_INIT       = 12'b0000_0000_0001,
      S_IDLE       = 12'b0000_0000_0010,
      S_FIND       = 12'b0000_0000_0100,
      S_DECIDE     = 12'b0000_0000_1000,
      S_SPLIT_RD   = 12'b0000_0001_0000,
      S_SPLIT_WAIT = 12'b0000_0010_0000,
      S_SPLIT_EMIT = 12'b0000_0100_0000,
      S_PR_RD      = 12'b0000_1000_0000,
      S_PR_WAIT    = 12'b0001_0000_0000,
      S_PR_SCAN    = 12'b0010_0000_0000,
      S_PR_KEEP    = 12'b0100_0000_0000,
      S_DONE       = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] ia_ff, ia_in, jb_ff, jb_in, ev_j_ff, ev_j_in;
   piece_type k_ff, k_in;
   logic rd_pend_ff, rd_pend_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ia_in = ia_ff;
      jb_in = jb_ff;
      k_in = k_ff;
      ev_j_in = jb_ff;
      rd_pend_in = 1'b0;
      cmd = '0;
      cmd.piece = k_ff;
      cmd.eval_same = (ev_j_ff == ia_ff);
      cmd.eval_later = (ev_j_ff > ia_ff);
      rd_addr = ia_ff[IDX_BITS-1:0];
      req_stall = 1'b1;

      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               if (req_action == ACTION_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.find_clr = 1'b1;
                  jb_in = '0;
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            // Reads are issued one per cycle; each is judged in the next cycle.
            cmd.find_eval = rd_pend_ff;
            rd_addr = jb_ff[IDX_BITS-1:0];
            if (jb_ff < free_count) begin
               cmd.rd_a_en = 1'b1;
               rd_pend_in = 1'b1;
               jb_in = jb_ff + COUNT_BITS'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.found) begin
               cmd.split_clr = 1'b1;
               ia_in = '0;
               state_in = S_SPLIT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SPLIT_RD: begin
            if (ia_ff < free_count) begin
               cmd.rd_a_en = 1'b1;
               state_in = S_SPLIT_WAIT;
            end else begin
               cmd.prune_clr = 1'b1;
               ia_in = '0;
               state_in = S_PR_RD;
            end
         end
         S_SPLIT_WAIT: begin
            cmd.split_latch = 1'b1;
            k_in = PIECE_LEFT;
            state_in = S_SPLIT_EMIT;
         end
         S_SPLIT_EMIT: begin
            cmd.split_emit = 1'b1;
            case (k_ff)
               PIECE_LEFT: k_in = PIECE_RIGHT;
               PIECE_RIGHT: k_in = PIECE_TOP;
               PIECE_TOP: k_in = PIECE_BOTTOM;
               default: begin
                  k_in = PIECE_LEFT;
                  ia_in = ia_ff + COUNT_BITS'(1);
                  state_in = S_SPLIT_RD;
               end
            endcase
         end
         S_PR_RD: begin
            if (ia_ff < split_count) begin
               cmd.rd_b_en = 1'b1;
               state_in = S_PR_WAIT;
            end else begin
               cmd.prune_done = 1'b1;
               state_in = S_DONE;
            end
         end
         S_PR_WAIT: begin
            cmd.prune_load = 1'b1;
            jb_in = '0;
            state_in = S_PR_SCAN;
         end
         S_PR_SCAN: begin
            cmd.prune_eval = rd_pend_ff;
            rd_addr = jb_ff[IDX_BITS-1:0];
            if (jb_ff < split_count) begin
               cmd.rd_b_en = 1'b1;
               rd_pend_in = 1'b1;
               jb_in = jb_ff + COUNT_BITS'(1);
            end else begin
               state_in = S_PR_KEEP;
            end
         end
         S_PR_KEEP: begin
            cmd.prune_keep = 1'b1;
            ia_in = ia_ff + COUNT_BITS'(1);
            state_in = S_PR_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ia_ff <= '0;
         jb_ff <= '0;
         ev_j_ff <= '0;
         k_ff <= PIECE_LEFT;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ia_ff <= ia_in;
         jb_ff <= jb_in;
         ev_j_ff <= ev_j_in;
         k_ff <= k_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/maxrects_best_short_side_packer.sv]
// Top level of the MaxRects best-short-side-fit atlas packer.
// One beat in gives one beat out. A clear beat writes the configured atlas and goes straight
// to the result. An insert searches the table of free rectangles for the best fit, splits each
// entry into the split buffer and then prunes the buffer back into the table; the search and
// the prune scans issue one table read per cycle through the single read port of each table.
// After reset the S_INIT state writes the initial atlas before the first beat is taken. Atlas
// size registers take effect at the next clear. A new request is taken while the previous
// result still waits in the output register.
module maxrects_best_short_side_packer import mrbss_pkg::*; #(
   parameter int MAX_FREE_RECTS = 64,
   parameter int COORD_BITS = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_addr,
   input  logic [REQ_BITS-1:0] csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [REQ_BITS-1:0] req_width,
   input  logic [REQ_BITS-1:0] req_height,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_placed,
   output logic [REQ_BITS-1:0] rsp_pos_x,
   output logic [REQ_BITS-1:0] rsp_pos_y,
   output logic                rsp_list_overflow
);

   localparam int IDX_BITS = $clog2(MAX_FREE_RECTS);
   localparam int COUNT_BITS = $clog2(MAX_FREE_RECTS + 1);

   dp_cmd_type cmd;
   dp_status_type status;
   logic [IDX_BITS-1:0] rd_addr;
   logic [COUNT_BITS-1:0] free_count, split_count;

   mrbss_ctrl #(
      .MAX_FREE_RECTS(MAX_FREE_RECTS),
      .IDX_BITS(IDX_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .free_count (free_count),
      .split_count(split_count),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   mrbss_dp #(
      .MAX_FREE_RECTS(MAX_FREE_RECTS),
      .COORD_BITS(COORD_BITS),
      .IDX_BITS(IDX_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .req_width        (req_width),
      .req_height       (req_height),
      .csr_wr_en        (csr_wr_en),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .rsp_placed       (rsp_placed),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_list_overflow(rsp_list_overflow),
      .free_count       (free_count),
      .split_count      (split_count),
      .status           (status)
   );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the best-short-side-fit atlas packer with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
   import mrbss_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int QUIET_LIMIT = 60000;

   typedef struct {
      int unsigned x0, y0, x1, y1;
   } free_box_type;

   typedef struct {
      logic                placed;
      logic [REQ_BITS-1:0] pos_x;
      logic [REQ_BITS-1:0] pos_y;
      logic                overflow;
   } placement_type;

   class packer_scoreboard;
      free_box_type  boxes[$];
      int unsigned   atlas_w, atlas_h;
      placement_type awaited[$];
      int            errors;
      int            inserts, placements, overflows, clears;

      function new();
         atlas_w = ATLAS_RESET;
         atlas_h = ATLAS_RESET;
         errors = 0;
         inserts = 0; placements = 0; overflows = 0; clears = 0;
         reset_atlas();
      endfunction

      function void reset_atlas();
         free_box_type b;
         b.x0 = 0; b.y0 = 0; b.x1 = atlas_w; b.y1 = atlas_h;
         boxes = {b};
      endfunction

      function void write_reg(logic idx, logic [REQ_BITS-1:0] value);
         if (idx == CSR_ATLAS_WIDTH) atlas_w = 32'(value);
         else atlas_h = 32'(value);
      endfunction

      function bit holds(free_box_type a, free_box_type b);
         return a.x0 >= b.x0 && a.y0 >= b.y0 && a.x1 <= b.x1 && a.y1 <= b.y1;
      endfunction

      function void cut(ref free_box_type nb[$], ref bit ovf, input int unsigned x0,
                        input int unsigned y0, input int unsigned x1, input int unsigned y1);
         free_box_type b;
         if (nb.size() >= TABLE_DEPTH) begin
            ovf = 1;
            return;
         end
         b.x0 = x0; b.y0 = y0; b.x1 = x1; b.y1 = y1;
         nb = {nb, b};
      endfunction

      // Works out the placement that one accepted request beat must produce.
      function void note_request(logic act, int unsigned w, int unsigned h);
         placement_type r;
         free_box_type  p, f;
         free_box_type  nb[$];
         bit            found, ovf, gone;
         int unsigned   best, fw, fh, s, i, j;
         r.placed = 0; r.pos_x = 0; r.pos_y = 0; r.overflow = 0;
         found = 0; ovf = 0; best = 0;
         p.x0 = 0; p.y0 = 0; p.x1 = 0; p.y1 = 0;
         if (act == ACTION_CLEAR) begin
            clears++;
            reset_atlas();
            awaited = {awaited, r};
            return;
         end
         inserts++;
         foreach (boxes[k]) begin
            fw = boxes[k].x1 - boxes[k].x0;
            fh = boxes[k].y1 - boxes[k].y0;
            if (fw >= w && fh >= h) begin
               s = (fw - w < fh - h) ? fw - w : fh - h;
               if (!found || s < best) begin
                  found = 1;
                  best = s;
                  p.x0 = boxes[k].x0; p.y0 = boxes[k].y0;
                  p.x1 = boxes[k].x0 + w; p.y1 = boxes[k].y0 + h;
               end
            end
         end
         if (found) begin
            foreach (boxes[k]) begin
               f = boxes[k];
               if (p.x1 <= f.x0 || p.x0 >= f.x1 || p.y1 <= f.y0 || p.y0 >= f.y1) begin
                  cut(nb, ovf, f.x0, f.y0, f.x1, f.y1);
               end else begin
                  if (p.x0 > f.x0) cut(nb, ovf, f.x0, f.y0, p.x0, f.y1);
                  if (p.x1 < f.x1) cut(nb, ovf, p.x1, f.y0, f.x1, f.y1);
                  if (p.y0 > f.y0) cut(nb, ovf, f.x0, f.y0, f.x1, p.y0);
                  if (p.y1 < f.y1) cut(nb, ovf, f.x0, p.y1, f.x1, f.y1);
               end
            end
            boxes = nb;
            // An entry held by a later one goes; a later one held by it goes instead.
            i = 0;
            while (i < boxes.size()) begin
               gone = 0;
               j = i + 1;
               while (j < boxes.size()) begin
                  if (holds(boxes[i], boxes[j])) begin
                     boxes.delete(i);
                     gone = 1;
                     break;
                  end else if (holds(boxes[j], boxes[i])) begin
                     boxes.delete(j);
                  end else begin
                     j++;
                  end
               end
               if (!gone) i++;
            end
            r.placed = 1;
            r.pos_x = REQ_BITS'(p.x0);
            r.pos_y = REQ_BITS'(p.y0);
            r.overflow = ovf;
            placements++;
            if (ovf) overflows++;
         end
         awaited = {awaited, r};
      endfunction

      function void check_placement(logic placed, logic [REQ_BITS-1:0] x,
                                    logic [REQ_BITS-1:0] y, logic ovf);
         placement_type e;
         if (awaited.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (placed !== e.placed) begin
            $error("placed: expected %0d, got %0d", e.placed, placed); errors++;
         end
         if (x !== e.pos_x) begin
            $error("pos_x: expected %0d, got %0d", e.pos_x, x); errors++;
         end
         if (y !== e.pos_y) begin
            $error("pos_y: expected %0d, got %0d", e.pos_y, y); errors++;
         end
         if (ovf !== e.overflow) begin
            $error("list_overflow: expected %0d, got %0d", e.overflow, ovf); errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                csr_wr_en = 0;
   logic                csr_addr = CSR_ATLAS_WIDTH;
   logic [REQ_BITS-1:0] csr_wdata = '0;
   logic                req_valid = 0;
   logic                req_stall;
   logic                req_action = ACTION_INSERT;
   logic [REQ_BITS-1:0] req_width = '0;
   logic [REQ_BITS-1:0] req_height = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic                rsp_placed;
   logic [REQ_BITS-1:0] rsp_pos_x;
   logic [REQ_BITS-1:0] rsp_pos_y;
   logic                rsp_list_overflow;

   packer_scoreboard sb = new();
   bit no_idle = 0;
   bit hold_off = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int quiet = 0;

   always #1 clock = ~clock;

   maxrects_best_short_side_packer dut (.*);

   // Receiver: checks result beats, stalls at random and once for a long stretch.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_placement(rsp_placed, rsp_pos_x, rsp_pos_y, rsp_list_overflow);
      if (hold_off && !hold_done) begin
         hold_done <= 1;
         hold_left <= 600;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("maxrects_best_short_side_packer: mismatch");
         $finish;
      end
   end

   task automatic send(logic act, logic [REQ_BITS-1:0] w, logic [REQ_BITS-1:0] h);
      if (!no_idle && $urandom_range(99) < 12) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_width <= w;
      req_height <= h;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, 32'(w), 32'(h));
   endtask

   // Writes both atlas size registers on consecutive edges.
   task automatic write_atlas(logic [REQ_BITS-1:0] w, logic [REQ_BITS-1:0] h);
      csr_wr_en <= 1;
      csr_addr <= CSR_ATLAS_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr <= CSR_ATLAS_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.write_reg(CSR_ATLAS_WIDTH, w);
      sb.write_reg(CSR_ATLAS_HEIGHT, h);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly small boxes so the free list fragments; now and then a large one or a clear beat.
   task automatic send_random(int count);
      int unsigned pick, w, h;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            send(ACTION_CLEAR, REQ_BITS'($urandom_range(8191)),
                 REQ_BITS'($urandom_range(8191)));
         end else begin
            if (pick < 70) begin
               w = $urandom_range(1, 64); h = $urandom_range(1, 64);
            end else if (pick < 90) begin
               w = $urandom_range(512); h = $urandom_range(512);
            end else begin
               w = $urandom_range(4096); h = $urandom_range(4096);
            end
            send(ACTION_INSERT, REQ_BITS'(w), REQ_BITS'(h));
         end
      end
   endtask

   task automatic new_atlas(logic [REQ_BITS-1:0] w, logic [REQ_BITS-1:0] h);
      drain();
      write_atlas(w, h);
      send(ACTION_CLEAR, 0, 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed beats on the reset atlas.
      send(ACTION_INSERT, 0, 0);
      send(ACTION_INSERT, 1024, 1024);
      send(ACTION_INSERT, 1, 1);
      send(ACTION_CLEAR, 13'h1fff, 13'h1fff);
      send(ACTION_INSERT, 4096, 4096);
      send(ACTION_INSERT, 1025, 1);
      send(ACTION_INSERT, 1024, 1);
      send(ACTION_INSERT, 1, 1023);
      send(ACTION_INSERT, 0, 5);
      send(ACTION_CLEAR, 0, 0);
      send(ACTION_INSERT, 100, 200);
      send(ACTION_INSERT, 300, 50);
      send(ACTION_INSERT, 200, 200);
      send(ACTION_INSERT, 100, 200);

      // Many small boxes to push the free list towards its limit.
      repeat (30) send(ACTION_INSERT, REQ_BITS'($urandom_range(1, 40)),
                       REQ_BITS'($urandom_range(1, 40)));

      // A stretch with no idling, then a long hold on the result side.
      no_idle = 1;
      send_random(20);
      no_idle = 0;
      hold_off <= 1;
      send_random(12);

      new_atlas(1, 4096);
      send(ACTION_INSERT, 1, 4096);
      send(ACTION_INSERT, 2, 1);
      send_random(6);

      new_atlas(4096, 1);
      send(ACTION_INSERT, 4096, 1);
      send_random(6);

      new_atlas(4096, 4096);
      send(ACTION_INSERT, 4096, 4096);
      send(ACTION_CLEAR, 0, 0);
      send_random(20);

      new_atlas(REQ_BITS'($urandom_range(1, 400)), REQ_BITS'($urandom_range(1, 400)));
      send_random(12);

      drain();
      $display("Covered %0d inserts (%0d placed, %0d overflowing) and %0d clears",
               sb.inserts, sb.placements, sb.overflows, sb.clears);
      $display("over atlas sizes from 1 to 4096 pixels, with idling and a long result hold.");
      if (sb.errors == 0)
         $display("maxrects_best_short_side_packer: match");
      else
         $display("maxrects_best_short_side_packer: mismatch");
      $finish;
   end

endmodule

[filelist.f]
rtl/mrbss_pkg.sv
rtl/mrbss_ram.sv
rtl/mrbss_dp.sv
rtl/mrbss_ctrl.sv
rtl/maxrects_best_short_side_packer.sv
bench/tb_top.sv
